@@ sv/assert_macros.svh @@
// assertion macros used by the checker file ppa_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// when pre holds, post holds at the following clock edge
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ sv/ppa_pkg.sv @@
// types, constants, the sample clamp and the gamma table function of the pixel accumulator
package ppa_pkg;

  localparam logic        CMD_ACCUM  = 1'b0;
  localparam logic        CMD_CLEAR  = 1'b1;
  localparam logic [16:0] SAMPLE_MAX = 17'd64880;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam int          CHANNELS   = 3;
  localparam logic [1:0]  CH_LAST    = 2'd2;
  localparam logic [3:0]  STEP_LAST  = 4'd15;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_IDX,
    ST_ROM,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] sum_red;
    logic [31:0] sum_green;
    logic [31:0] sum_blue;
    logic [15:0] count;
  } entry_t;

  function automatic logic [15:0] clamp_sample(input logic signed [17:0] s);
    logic [15:0] v;
    if (s[17]) begin
      v = '0;
    end else if ({1'b0, s[16:0]} > {1'b0, SAMPLE_MAX}) begin
      v = SAMPLE_MAX[15:0];
    end else begin
      v = s[15:0];
    end
    return v;
  endfunction

  // largest v with v^11 * n^5 <= 255^11 * k^5
  function automatic logic [7:0] gamma_entry(input int unsigned k, input int unsigned n);
    logic [191:0] rhs;
    logic [191:0] lhs;
    logic [7:0]   res;
    logic [7:0]   cand;
    rhs = 192'd1;
    for (int i = 0; i < 11; i++) rhs = rhs * 192'd255;
    for (int i = 0; i < 5; i++) rhs = rhs * 192'(k);
    res = '0;
    for (int b = 7; b >= 0; b--) begin
      cand = res | (8'd1 << b);
      lhs = 192'd1;
      for (int i = 0; i < 11; i++) lhs = lhs * 192'(cand);
      for (int i = 0; i < 5; i++) lhs = lhs * 192'(n);
      if (lhs <= rhs) res = cand;
    end
    return res;
  endfunction

endpackage

@@ sv/progressive_pixel_accumulator_core.sv @@
// progressive per-pixel sample accumulator with gamma 1/2.2 display bytes
//
// One word is taken at a time. The pixel entry is read from memory at the edge
// that takes the word. The word then passes through one read-modify-write of the
// pixel entry, 16 steps of a shared-step restoring divider (three channels side
// by side), the forming of the table index, three reads of the 4096-entry gamma
// rom (one per channel) and the loading of the output register. The next word
// can be taken in the cycle after that. The entry memory is cleared after reset
// by a pass over every address, during which in_stall is high.
// A finished word waits in the output register while the next one runs. The
// next word then waits in its last stage, with in_stall high, until the output
// register is free.
module progressive_pixel_accumulator_core #(
  parameter int PIXELS        = 262144,
  parameter int GAMMA_ENTRIES = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [17:0]        in_pixel_index,
  input  logic signed [17:0] in_sample_red,
  input  logic signed [17:0] in_sample_green,
  input  logic signed [17:0] in_sample_blue,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [17:0]        out_pixel,
  output logic [15:0]        out_mean_red,
  output logic [15:0]        out_mean_green,
  output logic [15:0]        out_mean_blue,
  output logic [7:0]         out_display_red,
  output logic [7:0]         out_display_green,
  output logic [7:0]         out_display_blue,
  output logic [15:0]        out_samples_taken,
  output logic               out_count_full
);
  import ppa_pkg::*;

  localparam int          AW        = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int          GW        = $clog2(GAMMA_ENTRIES);
  localparam logic [22:0] PIX_LIMIT = 23'(PIXELS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PIXELS - 1);
  localparam logic [32:0] GE_MUL    = 33'(GAMMA_ENTRIES);

  entry_t     mem [PIXELS];
  logic [7:0] gamma_rom [GAMMA_ENTRIES];

  for (genvar k = 0; k < GAMMA_ENTRIES; k++) begin : g_rom
    localparam logic [7:0] GV = gamma_entry(k, GAMMA_ENTRIES);
    assign gamma_rom[k] = GV;
  end

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_addr_r;
  logic          cmd_r;
  logic [17:0]   pix_r;
  logic          pix_ok_r;
  logic [15:0]   smp_r [CHANNELS];
  entry_t        rd_r;
  logic [15:0]   rem_r [CHANNELS];
  logic [15:0]   quo_r [CHANNELS];
  logic [15:0]   divisor_r;
  logic          zero_r;
  logic          full_r;
  logic [3:0]    step_r;
  logic [15:0]   mean_r [CHANNELS];
  logic [GW-1:0] idx_r [CHANNELS];
  logic [1:0]    ch_r;
  logic [7:0]    gam_r [CHANNELS];
  logic          out_valid_r;
  logic [17:0]   out_pixel_r;
  logic [15:0]   out_mean_r [CHANNELS];
  logic [7:0]    out_disp_r [CHANNELS];
  logic [15:0]   out_cnt_r;
  logic          out_full_r;

  logic          accept;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  entry_t        mem_wdata;
  entry_t        new_entry;
  entry_t        res_entry;
  logic          full_new;
  logic [31:0]   res_sum [CHANNELS];
  logic [16:0]   trial [CHANNELS];
  logic          ge [CHANNELS];
  logic [32:0]   prod [CHANNELS];
  logic          out_load;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // read-modify-write of the entry
  always_comb begin
    full_new  = (cmd_r == CMD_ACCUM) && (rd_r.count == COUNT_MAX);
    new_entry = rd_r;
    if (cmd_r == CMD_CLEAR) begin
      new_entry = '0;
    end else if (!full_new) begin
      new_entry.sum_red   = rd_r.sum_red + 32'(smp_r[0]);
      new_entry.sum_green = rd_r.sum_green + 32'(smp_r[1]);
      new_entry.sum_blue  = rd_r.sum_blue + 32'(smp_r[2]);
      new_entry.count     = rd_r.count + 16'd1;
    end
    res_entry  = pix_ok_r ? new_entry : '0;
    res_sum[0] = res_entry.sum_red;
    res_sum[1] = res_entry.sum_green;
    res_sum[2] = res_entry.sum_blue;
  end

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      trial[c] = {rem_r[c], quo_r[c][15]};
      ge[c]    = trial[c] >= {1'b0, divisor_r};
      prod[c]  = 33'(quo_r[c]) * GE_MUL;
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = AW'(pix_r);
    mem_wdata = new_entry;
    out_load  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = '0;
        if (clr_addr_r == LAST_ADDR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        mem_addr = AW'(in_pixel_index);
        mem_re   = accept;
        if (accept) state_nxt = ST_READ;
      end
      ST_READ: begin
        mem_we    = pix_ok_r && !full_new;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (step_r == STEP_LAST) state_nxt = ST_IDX;
      end
      ST_IDX: begin
        state_nxt = ST_ROM;
      end
      ST_ROM: begin
        if (ch_r == CH_LAST) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      step_r     <= '0;
      ch_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
      if (state_r == ST_DIV) step_r <= step_r + 4'd1;
      else step_r <= '0;
      if (state_r == ST_ROM) ch_r <= (ch_r == CH_LAST) ? 2'd0 : ch_r + 2'd1;
      else ch_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      pix_r    <= in_pixel_index;
      pix_ok_r <= {5'd0, in_pixel_index} < PIX_LIMIT;
      smp_r[0] <= clamp_sample(in_sample_red);
      smp_r[1] <= clamp_sample(in_sample_green);
      smp_r[2] <= clamp_sample(in_sample_blue);
    end
    if (state_r == ST_READ) begin
      divisor_r <= res_entry.count;
      zero_r    <= (res_entry.count == 16'd0);
      full_r    <= pix_ok_r && full_new;
      for (int c = 0; c < CHANNELS; c++) begin
        rem_r[c] <= res_sum[c][31:16];
        quo_r[c] <= res_sum[c][15:0];
      end
    end
    if (state_r == ST_DIV) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rem_r[c] <= ge[c] ? 16'(trial[c] - {1'b0, divisor_r}) : trial[c][15:0];
        quo_r[c] <= {quo_r[c][14:0], ge[c]};
      end
    end
    if (state_r == ST_IDX) begin
      for (int c = 0; c < CHANNELS; c++) begin
        mean_r[c] <= zero_r ? 16'd0 : quo_r[c];
        idx_r[c]  <= zero_r ? '0 : prod[c][16 +: GW];
      end
    end
    if (state_r == ST_ROM) gam_r[ch_r] <= gamma_rom[idx_r[ch_r]];
    if (out_load) begin
      out_pixel_r <= pix_r;
      out_cnt_r   <= divisor_r;
      out_full_r  <= full_r;
      for (int c = 0; c < CHANNELS; c++) begin
        out_mean_r[c] <= mean_r[c];
        out_disp_r[c] <= gam_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel         = out_pixel_r;
  assign out_mean_red      = out_mean_r[0];
  assign out_mean_green    = out_mean_r[1];
  assign out_mean_blue     = out_mean_r[2];
  assign out_display_red   = out_disp_r[0];
  assign out_display_green = out_disp_r[1];
  assign out_display_blue  = out_disp_r[2];
  assign out_samples_taken = out_cnt_r;
  assign out_count_full    = out_full_r;

endmodule

@@ sv/ppa_checker.sv @@
// port-level checks of the pixel accumulator and their bind
`include "assert_macros.svh"

module ppa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [17:0] out_pixel,
  input logic [15:0] out_mean_red,
  input logic [15:0] out_mean_green,
  input logic [15:0] out_mean_blue,
  input logic [7:0]  out_display_red,
  input logic [7:0]  out_display_green,
  input logic [7:0]  out_display_blue,
  input logic [15:0] out_samples_taken,
  input logic        out_count_full
);

  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped while stalled")
  `ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_pixel) && $stable(out_samples_taken), "stalled result word changed")
  `ASSERT_ALWAYS(a_full_count, !(out_valid && out_count_full) || (out_samples_taken == 16'hFFFF), "count_full with unsaturated count")
  `ASSERT_ALWAYS(a_empty_zero, !(out_valid && out_samples_taken == 16'd0) || (out_mean_red == 16'd0 && out_mean_green == 16'd0 && out_mean_blue == 16'd0 && out_display_red == 8'd0 && out_display_green == 8'd0 && out_display_blue == 8'd0), "nonzero result for empty pixel")

endmodule

bind progressive_pixel_accumulator_core ppa_checker u_ppa_checker (.*);
